@@ hdl/ifrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_pkg
// Shared constants and types of the fragment release tracker.
// ----------------------------------------------------------------------------
package ifrt_pkg;

  localparam int FRAG_SLOTS = 8;
  localparam int SLOT_W     = $clog2(FRAG_SLOTS);
  localparam int MID_W      = $clog2(FRAG_SLOTS + 1);

  localparam logic [SLOT_W-1:0] FIRST_SLOT   = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(1);
  localparam logic [MID_W-1:0]  MIDDLE_START = MID_W'(2);

  localparam logic [16:0] SUM_MAX = 17'h1FFFF;

  // release_mode codes; anything above MODE_INORDER acts as MODE_COMPLETE
  localparam logic [1:0] MODE_OOO      = 2'd0;
  localparam logic [1:0] MODE_INORDER  = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    logic [15:0]       wr_handle;
    logic              rel_en;
    logic [SLOT_W-1:0] rel_idx;
    logic              clr;
  } slot_ctrl_t;

endpackage

@@ hdl/ifrt_slots.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrt_slots
// Slot store: buffer handles plus held and released flags per slot.
// ----------------------------------------------------------------------------
module ifrt_slots import ifrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  slot_ctrl_t            ctrl,
  input  logic [SLOT_W-1:0]     rd_idx,
  output logic [FRAG_SLOTS-1:0] held,
  output logic [FRAG_SLOTS-1:0] released,
  output logic [15:0]           rd_handle
);

  logic [15:0] slot_handle [FRAG_SLOTS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      slot_handle[ctrl.wr_idx] <= ctrl.wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      held     <= '0;
      released <= '0;
    end else begin
      for (int i = 0; i < FRAG_SLOTS; i++) begin
        if (ctrl.wr_en && ctrl.wr_idx == SLOT_W'(i)) begin
          held[i]     <= 1'b1;
          released[i] <= 1'b0;
        end else if (ctrl.rel_en && ctrl.rel_idx == SLOT_W'(i)) begin
          held[i]     <= 1'b0;
          released[i] <= 1'b1;
        end
      end
    end
  end

  assign rd_handle = slot_handle[rd_idx];

endmodule

@@ hdl/ip_fragment_release_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_fragment_release_tracker
// Holds the fragment handles of one datagram and releases them by mode.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes ACCUM, then DECIDE unless it is rejected,
//   then SCAN if anything is to be released, then FINISH, where the last
//   result is pushed; the release scan visits one slot per cycle unless the
//   output stalls, and in-order mode stops at the first gap. A new request is
//   taken only once the last is done: in_ready is high only in idle. Output back-pressure adds stalls.
// Reset (synchronous): entry cleared, release_mode 0, no result pending.
// ----------------------------------------------------------------------------
module ip_fragment_release_tracker import ifrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frag_handle,
  input  logic [15:0] byte_offset,
  input  logic [15:0] frag_length,
  input  logic        more_follow,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        handle_valid,
  output logic [15:0] released_handle,
  output logic        error,
  output logic        completed,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  state_t state, state_next;

  logic [1:0]  release_mode;
  logic [15:0] in_handle;
  logic [15:0] in_offset;
  logic [15:0] in_length;
  logic        in_more;

  logic [16:0]      bytes_received;
  logic [16:0]      expected_total;
  logic             total_known;
  logic [MID_W-1:0] next_middle_slot;

  logic [SLOT_W-1:0] slot_idx;
  logic [SLOT_W-1:0] scan_i;
  logic              err;
  logic              cmp;
  logic              single;
  logic              inorder;
  logic              pend_valid;
  logic [15:0]       pend_handle;

  slot_ctrl_t            sctrl;
  logic [FRAG_SLOTS-1:0] held;
  logic [FRAG_SLOTS-1:0] released;
  logic [15:0]           rd_handle;

  ifrt_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctrl),
    .rd_idx    (scan_i),
    .held      (held),
    .released  (released),
    .rd_handle (rd_handle)
  );

  // ---- datapath terms ----
  logic [17:0]       sum_wide;
  logic [16:0]       sum_sat;
  logic              is_first, is_last, is_mid;
  logic              acc_err;
  logic [SLOT_W-1:0] acc_idx;
  logic              dec_cmp, dec_rel;
  logic              scan_stop, scan_rel, scan_stall, scan_end;
  logic              fin_push, fin_stall;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  assign sum_wide = {1'b0, bytes_received} + {2'b00, in_length};
  assign sum_sat  = sum_wide[17] ? SUM_MAX : sum_wide[16:0];
  assign is_first = (in_offset == 16'd0);
  assign is_last  = !is_first && !in_more;
  assign is_mid   = !is_first && in_more;
  assign acc_err  = (in_length == 16'd0) ||
                    (is_first && held[FIRST_SLOT]) ||
                    (is_last && held[LAST_SLOT]) ||
                    (is_mid && next_middle_slot >= MID_W'(FRAG_SLOTS));
  assign acc_idx  = is_first ? FIRST_SLOT :
                    is_last  ? LAST_SLOT  : next_middle_slot[SLOT_W-1:0];

  assign dec_cmp = total_known && (bytes_received == expected_total);
  // no handle is released until the first fragment has been seen
  assign dec_rel = (held[FIRST_SLOT] || released[FIRST_SLOT]) &&
                   (release_mode == MODE_OOO || release_mode == MODE_INORDER ||
                    dec_cmp);

  assign scan_stop  = inorder && !held[scan_i] && !released[scan_i];
  assign scan_rel   = held[scan_i] && (!single || scan_i == slot_idx);
  assign scan_stall = scan_rel && pend_valid && !out_free;
  assign scan_end   = (scan_i == SLOT_W'(FRAG_SLOTS - 1));

  assign fin_push  = err || pend_valid || cmp;
  assign fin_stall = fin_push && !out_free;

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = acc_err ? ST_FINISH : ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = dec_rel ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (scan_stop) state_next = ST_FINISH;
        else if (!scan_stall && scan_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!fin_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  logic        push;
  logic        push_hv;
  logic [15:0] push_handle;
  logic        push_err;
  logic        push_last;
  logic        clear_all;
  logic        pend_load;

  always_comb begin
    push        = 1'b0;
    push_hv     = 1'b0;
    push_handle = 16'd0;
    push_err    = 1'b0;
    push_last   = 1'b0;
    clear_all   = 1'b0;
    pend_load   = 1'b0;
    sctrl       = '0;
    unique case (state)
      ST_ACCUM: begin
        sctrl.wr_en     = !acc_err;
        sctrl.wr_idx    = acc_idx;
        sctrl.wr_handle = in_handle;
      end
      ST_SCAN: begin
        if (scan_rel && !scan_stall) begin
          pend_load     = 1'b1;
          sctrl.rel_en  = 1'b1;
          sctrl.rel_idx = scan_i;
          // previous release goes out now that it is known not to be last
          push          = pend_valid;
          push_hv       = 1'b1;
          push_handle   = pend_handle;
        end
      end
      ST_FINISH: begin
        if (!fin_stall) begin
          push        = fin_push;
          push_hv     = !err && pend_valid;
          push_handle = (!err && pend_valid) ? pend_handle : 16'd0;
          push_err    = err;
          push_last   = 1'b1;
          clear_all   = err || cmp;
          sctrl.clr   = err || cmp;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_mode <= MODE_OOO;
    end else if (cfg_valid && cfg_ready) begin
      release_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_handle <= frag_handle;
      in_offset <= byte_offset;
      in_length <= frag_length;
      in_more   <= more_follow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      bytes_received   <= '0;
      expected_total   <= '0;
      total_known      <= 1'b0;
      next_middle_slot <= MIDDLE_START;
    end else if (state == ST_ACCUM) begin
      bytes_received <= sum_sat;
      if (is_last) begin
        expected_total <= {1'b0, in_offset} + {1'b0, in_length};
        total_known    <= 1'b1;
      end
      if (is_mid && !acc_err) next_middle_slot <= next_middle_slot + MID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err        <= 1'b0;
      cmp        <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_ACCUM: begin
          err        <= acc_err;
          cmp        <= 1'b0;
          pend_valid <= 1'b0;
          slot_idx   <= acc_idx;
        end
        ST_DECIDE: begin
          cmp     <= dec_cmp;
          single  <= (release_mode == MODE_OOO) && released[FIRST_SLOT];
          inorder <= (release_mode == MODE_INORDER);
          scan_i  <= '0;
        end
        ST_SCAN: begin
          if (pend_load) begin
            pend_valid  <= 1'b1;
            pend_handle <= rd_handle;
          end
          if (!scan_stall && !scan_end) scan_i <= scan_i + SLOT_W'(1);
        end
        ST_FINISH: begin
          if (!fin_stall) begin
            pend_valid <= 1'b0;
            err        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      handle_valid    <= push_hv;
      released_handle <= push_handle;
      error           <= push_err;
      completed       <= cmp && !push_err;
      last_of_run     <= push_last;
    end
  end

`ifndef SYNTHESIS
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !handle_valid && !completed && last_of_run)
    else $error("error result carries other flags");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous still in work");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending release left over in idle");

  a_no_push_over: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result register overwritten");
`endif

endmodule
